// File: rtl/rsl_pkg.sv
// rsl_pkg: shared constants and codes for the radial spotlight luminance unit
// used by every module under rtl; depends on nothing

package rsl_pkg;

  // default widths of coordinates and luminance
  localparam int COORD_BITS_DEF = 12;
  localparam int LUM_BITS_DEF   = 16;

  // distance format: pixels with four fraction bits
  localparam int FRAC_BITS = 4;

  // root width: the limit of 160 px in sixteenths is 2560, below 2^12
  localparam int ROOT_W = 12;
  // radicand is two bits per root bit
  localparam int RAD_W  = 2 * ROOT_W;
  // partial remainder with room for two shifted-in bits
  localparam int REM_W  = ROOT_W + 3;

  // squared distance at which the limit is reached: 160 * 160
  localparam int SAT_SQ    = 25600;
  // unsaturated squared distance is below SAT_SQ and fits in this many bits
  localparam int SQ_KEEP_W = 15;

  // distance limit and full scale of the falloff, in sixteenths of a pixel
  localparam logic [ROOT_W-1:0] DIST_LIMIT_Q = 12'd2560;
  localparam logic [ROOT_W-1:0] FULL_SCALE_Q = 12'd3200;

  // full scale split as 25 << 7 for the constant divide
  localparam int SCALE_SHIFT = 7;
  localparam int SCALE_ODD   = 25;

  // configuration register index
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1
  } cfg_reg_e;

endpackage

// File: rtl/rsl_front.sv
// rsl_front: distance front end, abs differences, squares, sum and limit check
// three pipeline stages; depends on rsl_pkg

module rsl_front #(
  parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF,
  parameter int LUM_BITS   = rsl_pkg::LUM_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [COORD_BITS-1:0]    pixel_x_i,
  input  logic [COORD_BITS-1:0]    pixel_y_i,
  input  logic [LUM_BITS-1:0]      lum_i,
  input  logic [COORD_BITS-1:0]    center_x_i,
  input  logic [COORD_BITS-1:0]    center_y_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic [rsl_pkg::RAD_W-1:0] rad_o,
  output logic                     sat_o,
  output logic [LUM_BITS-1:0]      lum_o
);

  localparam int SQ_W = 2 * COORD_BITS + 1;
  localparam int PR_W = 2 * COORD_BITS;

  logic [2:0]            v_q;
  logic [3:0]            rdy;

  logic [COORD_BITS-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [LUM_BITS-1:0]   lum0_q, lum1_q, lum2_q;
  logic [PR_W-1:0]       sqx_q, sqy_q;
  logic [SQ_W-1:0]       sum;
  logic [rsl_pkg::RAD_W-1:0] rad_q;
  logic                  sat_q;

  // stage ready chain: a stage moves when it is empty or its successor moves
  always_comb begin
    rdy[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[2];

  // absolute coordinate differences
  always_comb begin
    dx_d = (pixel_x_i >= center_x_i) ? pixel_x_i - center_x_i : center_x_i - pixel_x_i;
    dy_d = (pixel_y_i >= center_y_i) ? pixel_y_i - center_y_i : center_y_i - pixel_y_i;
  end

  // squared distance and limit check
  assign sum = SQ_W'(sqx_q) + SQ_W'(sqy_q);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      lum0_q <= lum_i;
    end
    if (rdy[1] && v_q[0]) begin
      sqx_q  <= dx_q * dx_q;
      sqy_q  <= dy_q * dy_q;
      lum1_q <= lum0_q;
    end
    if (rdy[2] && v_q[1]) begin
      sat_q  <= (sum >= SQ_W'(rsl_pkg::SAT_SQ));
      rad_q  <= rsl_pkg::RAD_W'({sum[rsl_pkg::SQ_KEEP_W-1:0],
                                 (2 * rsl_pkg::FRAC_BITS)'(0)});
      lum2_q <= lum1_q;
    end
  end

  assign rad_o = rad_q;
  assign sat_o = sat_q;
  assign lum_o = lum2_q;

endmodule

// File: rtl/rsl_sqrt_cell.sv
// rsl_sqrt_cell: one cell of the square root chain, settles one root bit
// registered with its own valid and ready; depends on rsl_pkg

module rsl_sqrt_cell #(
  parameter int BIT    = 0,
  parameter int SIDE_W = rsl_pkg::LUM_BITS_DEF + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [rsl_pkg::RAD_W-1:0]  rad_i,
  input  logic [rsl_pkg::REM_W-1:0]  rem_i,
  input  logic [rsl_pkg::ROOT_W-1:0] root_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [rsl_pkg::RAD_W-1:0]  rad_o,
  output logic [rsl_pkg::REM_W-1:0]  rem_o,
  output logic [rsl_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int REM_W  = rsl_pkg::REM_W;
  localparam int ROOT_W = rsl_pkg::ROOT_W;

  logic                      valid_q;
  logic [rsl_pkg::RAD_W-1:0] rad_q;
  logic [REM_W-1:0]          rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]         root_q, root_d;
  logic [SIDE_W-1:0]         side_q;
  logic                      take;

  assign ready_o = !valid_q || ready_i;

  // bring down two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[2*BIT+1 -: 2]};
    trial  = REM_W'({root_i, 2'b01});
    take   = (rem_sh >= trial);
    rem_d  = take ? rem_sh - trial : rem_sh;
    root_d = {root_i[ROOT_W-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rad_q  <= rad_i;
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

// File: rtl/rsl_scale.sv
// rsl_scale: luminance falloff, lum * (3200 - d16) / 3200 truncated
// product, reciprocal multiply, correction and output register; depends on rsl_pkg

module rsl_scale #(
  parameter int LUM_BITS = rsl_pkg::LUM_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [rsl_pkg::ROOT_W-1:0] d16_i,
  input  logic                       sat_i,
  input  logic [LUM_BITS-1:0]        lum_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [LUM_BITS-1:0]        lum_out_o,
  output logic                       sat_o
);

  localparam int PROD_W  = LUM_BITS + rsl_pkg::ROOT_W;
  localparam int Q_W     = PROD_W - rsl_pkg::SCALE_SHIFT;
  localparam int K       = Q_W + 1;
  localparam int RECIP_W = K - 4;
  localparam int EST_W   = Q_W + RECIP_W - K;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << K) / 64'd25);

  logic [2:0]               v_q;
  logic [3:0]               rdy;
  logic [PROD_W-1:0]        prod_q;
  logic [Q_W-1:0]           q_q;
  logic [Q_W+RECIP_W-1:0]   est_full_q;
  logic [1:0]               sat_q;
  logic                     sat_out_q;
  logic [EST_W-1:0]         est;
  logic [Q_W-1:0]           rem;
  logic                     corr;
  logic [LUM_BITS-1:0]      lum_out_q;

  always_comb begin
    rdy[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[2];

  // quotient estimate is low by at most one, fix with the remainder
  always_comb begin
    est  = est_full_q[Q_W+RECIP_W-1:K];
    rem  = q_q - Q_W'(Q_W'(est) * Q_W'(rsl_pkg::SCALE_ODD));
    corr = (rem >= Q_W'(rsl_pkg::SCALE_ODD));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    // lum times remaining factor in sixteenths
    if (rdy[0] && valid_i) begin
      prod_q   <= PROD_W'(lum_i) * PROD_W'(rsl_pkg::FULL_SCALE_Q - d16_i);
      sat_q[0] <= sat_i;
    end
    // drop the power of two, multiply by the reciprocal of 25
    if (rdy[1] && v_q[0]) begin
      q_q        <= prod_q[PROD_W-1:rsl_pkg::SCALE_SHIFT];
      est_full_q <= prod_q[PROD_W-1:rsl_pkg::SCALE_SHIFT] * RECIP;
      sat_q[1]   <= sat_q[0];
    end
    // output register
    if (rdy[2] && v_q[1]) begin
      lum_out_q <= LUM_BITS'(est) + LUM_BITS'(corr);
      sat_out_q <= sat_q[1];
    end
  end

  assign lum_out_o = lum_out_q;
  assign sat_o     = sat_out_q;

endmodule

// File: rtl/radial_spotlight_luminance_unit.sv
// radial_spotlight_luminance_unit: top level of the radial vignette luminance falloff
// uses rsl_pkg, rsl_front, rsl_sqrt_cell and rsl_scale
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    pixel_x_i, pixel_y_i, lum_in_i
//   out      output     out_valid_o / out_stall_i  lum_out_o, dist_saturated_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// one item per cycle sustained while out_stall_i is low; stages: three front stages, one square
// root cell per distance bit (12 cells), three scale stages incl. the output register
// every stage has its own valid, so bubbles are squeezed out under output stall
// reset clears all stage valids and both center registers, no clearing pass
// in_stall_o rises only when every stage is full and the output is stalled

module radial_spotlight_luminance_unit #(
  parameter int COORD_BITS = rsl_pkg::COORD_BITS_DEF,
  parameter int LUM_BITS   = rsl_pkg::LUM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COORD_BITS-1:0]         pixel_x_i,
  input  logic [COORD_BITS-1:0]         pixel_y_i,
  input  logic [LUM_BITS-1:0]           lum_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [LUM_BITS-1:0]           lum_out_o,
  output logic                          dist_saturated_o,
  input  logic                          cfg_we_i,
  input  logic [rsl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_BITS-1:0]         cfg_data_i
);

  localparam int ROOT_W = rsl_pkg::ROOT_W;
  localparam int SIDE_W = LUM_BITS + 1;

  logic [COORD_BITS-1:0] center_x_q, center_y_q;

  logic                      front_ready;
  logic                      front_valid;
  logic [rsl_pkg::RAD_W-1:0] front_rad;
  logic                      front_sat;
  logic [LUM_BITS-1:0]       front_lum;

  logic                      cell_valid [ROOT_W+1];
  logic                      cell_ready [ROOT_W+1];
  logic [rsl_pkg::RAD_W-1:0] cell_rad   [ROOT_W+1];
  logic [rsl_pkg::REM_W-1:0] cell_rem   [ROOT_W+1];
  logic [ROOT_W-1:0]         cell_root  [ROOT_W+1];
  logic [SIDE_W-1:0]         cell_side  [ROOT_W+1];

  logic                      sq_sat;
  logic [ROOT_W-1:0]         d16;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsl_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i;
        rsl_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // differences, squares and limit check
  rsl_front #(
    .COORD_BITS (COORD_BITS),
    .LUM_BITS   (LUM_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (front_ready),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .lum_i      (lum_in_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .valid_o    (front_valid),
    .ready_i    (cell_ready[0]),
    .rad_o      (front_rad),
    .sat_o      (front_sat),
    .lum_o      (front_lum)
  );

  assign in_stall_o = !front_ready;

  // chain head
  assign cell_valid[0] = front_valid;
  assign cell_rad[0]   = front_rad;
  assign cell_rem[0]   = '0;
  assign cell_root[0]  = '0;
  assign cell_side[0]  = {front_sat, front_lum};

  // square root chain, most significant root bit first
  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    rsl_sqrt_cell #(
      .BIT    (ROOT_W - 1 - i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[i]),
      .ready_o (cell_ready[i]),
      .rad_i   (cell_rad[i]),
      .rem_i   (cell_rem[i]),
      .root_i  (cell_root[i]),
      .side_i  (cell_side[i]),
      .valid_o (cell_valid[i+1]),
      .ready_i (cell_ready[i+1]),
      .rad_o   (cell_rad[i+1]),
      .rem_o   (cell_rem[i+1]),
      .root_o  (cell_root[i+1]),
      .side_o  (cell_side[i+1])
    );
  end

  // saturated distance is pinned to the limit
  assign sq_sat = cell_side[ROOT_W][SIDE_W-1];
  assign d16    = sq_sat ? rsl_pkg::DIST_LIMIT_Q : cell_root[ROOT_W];

  rsl_scale #(
    .LUM_BITS (LUM_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (cell_valid[ROOT_W]),
    .ready_o   (cell_ready[ROOT_W]),
    .d16_i     (d16),
    .sat_i     (sq_sat),
    .lum_i     (cell_side[ROOT_W][LUM_BITS-1:0]),
    .valid_o   (out_valid_o),
    .ready_i   (!out_stall_i),
    .lum_out_o (lum_out_o),
    .sat_o     (dist_saturated_o)
  );

  // unsaturated root stays below the limit
  a_root_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[ROOT_W] && !sq_sat |-> cell_root[ROOT_W] < rsl_pkg::DIST_LIMIT_Q)
    else $error("square root reached the limit without saturation");

  // input backs up only behind a stalled, full pipeline
  a_stall_needs_output_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  // a center x write lands
  a_cfg_center_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == rsl_pkg::CFG_CENTER_X |=> center_x_q == $past(cfg_data_i))
    else $error("center x write lost");

endmodule
